// ----- rtl/bdm_pkg.sv -----
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared types and constants of the RGGB Bayer bilinear demosaic block.
// ----------------------------------------------------------------------------
package bdm_pkg;

   typedef logic [7:0] pix_type;

   // 3x3 neighborhood, [row][column]; row 0 is the upper line, column 2 newest
   typedef pix_type [2:0][2:0] window_type;

   typedef struct packed {
      logic       mode;
      logic [9:0] raw_sample;
   } req_word_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic       frame_end;
   } rsp_word_type;

   // position of the pixel that leaves the window stage
   typedef struct packed {
      logic top;
      logic bot;
      logic lef;
      logic rig;
      logic oddr;
      logic oddc;
      logic last;
   } pos_flags_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_ORDER = 2'd2;

   localparam logic [12:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd480;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_FLUSH  = 1'b1;

   localparam logic ORDER_BGR = 1'b0;
   localparam logic ORDER_RGB = 1'b1;

endpackage

// ----- rtl/bdm_if.sv -----
// ----------------------------------------------------------------------------
// bdm_req_if / bdm_rsp_if
// Valid/ready channels of the demosaic block: raw samples in, pixels out.
// ----------------------------------------------------------------------------
interface bdm_req_if;
   import bdm_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bdm_rsp_if;
   import bdm_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bdm_line_mem.sv -----
// ----------------------------------------------------------------------------
// bdm_line_mem
// One line store: single write port, one registered read port.
// ----------------------------------------------------------------------------
module bdm_line_mem #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  bdm_pkg::pix_type         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output bdm_pkg::pix_type         rd_data
);
   import bdm_pkg::*;

   pix_type store_ff [DEPTH];
   pix_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bdm_interp.sv -----
// ----------------------------------------------------------------------------
// bdm_interp
// Bilinear color reconstruction of the window center, with border rules.
// ----------------------------------------------------------------------------
module bdm_interp (
   input  bdm_pkg::window_type    win,
   input  bdm_pkg::pos_flags_type flags,
   input  logic                   output_order,
   output bdm_pkg::rsp_word_type  word
);
   import bdm_pkg::*;

   // x/3 == (x*683)>>11 for every x below 2048
   localparam logic [9:0] RECIP3       = 10'd683;
   localparam int         RECIP3_SHIFT = 11;

   // {count, sum} of the selected neighbors
   function automatic logic [12:0] pick4(input logic [3:0] sel,
                                         input pix_type v0, input pix_type v1,
                                         input pix_type v2, input pix_type v3);
      logic [9:0] sum;
      logic [2:0] cnt;
      sum = 10'd0;
      cnt = 3'd0;
      if (sel[0]) begin sum = sum + {2'b00, v0}; cnt = cnt + 3'd1; end
      if (sel[1]) begin sum = sum + {2'b00, v1}; cnt = cnt + 3'd1; end
      if (sel[2]) begin sum = sum + {2'b00, v2}; cnt = cnt + 3'd1; end
      if (sel[3]) begin sum = sum + {2'b00, v3}; cnt = cnt + 3'd1; end
      return {cnt, sum};
   endfunction

   // mean over one, two or four terms
   function automatic pix_type shift_mean(input logic [12:0] cs);
      pix_type res;
      case (cs[12:10])
         3'd2:    res = cs[8:1];
         3'd4:    res = cs[9:2];
         default: res = cs[7:0];
      endcase
      return res;
   endfunction

   pix_type a, b, l, r, al, ar, bl, br, s;
   logic [12:0] g_cs, d_cs, h_cs, v_cs;
   logic [3:0]  g_sel;
   logic [19:0] g_prod;
   pix_type     grn_avg, diag, horiz, vert;
   pix_type     red, grn, blu;
   logic        rig_blue;

   always_comb begin
      a  = win[0][1];
      b  = win[2][1];
      l  = win[1][0];
      r  = win[1][2];
      al = win[0][0];
      ar = win[0][2];
      bl = win[2][0];
      br = win[2][2];
      s  = win[1][1];

      // blue site on the right column above the bottom: vertical green only
      rig_blue = flags.oddr && flags.oddc && flags.rig && !flags.bot;
      if (rig_blue) begin
         g_sel = {1'b0, 1'b0, 1'b1, !flags.top};
      end else begin
         g_sel = {!flags.rig, !flags.lef, !flags.bot, !flags.top};
      end
      g_cs   = pick4(g_sel, a, b, l, r);
      g_prod = g_cs[9:0] * RECIP3;
      case (g_cs[12:10])
         3'd2:    grn_avg = g_cs[8:1];
         3'd3:    grn_avg = g_prod[RECIP3_SHIFT+7:RECIP3_SHIFT];
         3'd4:    grn_avg = g_cs[9:2];
         default: grn_avg = g_cs[7:0];
      endcase

      d_cs = pick4({!flags.bot && !flags.rig, !flags.bot && !flags.lef,
                    !flags.top && !flags.rig, !flags.top && !flags.lef},
                   al, ar, bl, br);
      h_cs = pick4({2'b00, !flags.rig, !flags.lef}, l, r, 8'd0, 8'd0);
      v_cs = pick4({2'b00, !flags.bot, !flags.top}, a, b, 8'd0, 8'd0);
      diag  = shift_mean(d_cs);
      horiz = shift_mean(h_cs);
      vert  = shift_mean(v_cs);

      case ({flags.oddr, flags.oddc})
         2'b00: begin
            red = s;
            grn = grn_avg;
            blu = diag;
         end
         2'b11: begin
            red = diag;
            grn = grn_avg;
            blu = s;
         end
         2'b01: begin
            red = horiz;
            grn = s;
            blu = vert;
         end
         default: begin
            red = vert;
            grn = s;
            blu = horiz;
         end
      endcase

      word.byte0     = (output_order == ORDER_RGB) ? red : blu;
      word.byte1     = grn;
      word.byte2     = (output_order == ORDER_RGB) ? blu : red;
      word.frame_end = flags.last;
   end

endmodule

// ----- rtl/bayer_rggb10_bilinear_demosaic_top.sv -----
// ----------------------------------------------------------------------------
// bayer_rggb10_bilinear_demosaic_top
// RGGB Bayer to 24-bit color, bilinear, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries raster-order words: mode 0 with a 10-bit sample, or
//   mode 1 flush ticks. After the last sample of a frame send width+1 flush
//   ticks to drain the final row; a flush inside the frame is dropped.
//   rsp_chan returns one color word per sample, lagging the input by one row
//   plus one pixel; frame_end marks the last pixel of the frame.
//   csr_* writes frame width, height and byte order; write only while idle.
// Timing:
//   One word is accepted every clock unless a stall drops req_chan.ready. A
//   result word appears on rsp_chan once the input word that completes its
//   3x3 window has passed the window/line-store stage and the interpolation
//   stage that feeds the output register. Line store reads are prefetched at
//   the next column, so the memory read port sets no limit on rate.
// Reset:
//   Synchronous reset clears counters, valids and config to defaults; data
//   registers and line stores are not cleared, and need no clearing pass.
// Stall:
//   When rsp_chan.ready is low the output register holds, the window stage
//   holds one more word, and req_chan.ready drops only once both are full.
// ----------------------------------------------------------------------------
module bayer_rggb10_bilinear_demosaic_top #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bdm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bdm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   bdm_req_if.sink                          req_chan,
   bdm_rsp_if.source                        rsp_chan
);
   import bdm_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = CW + 1;
   localparam int XW  = (WW > 13) ? WW : 13;
   localparam int CAP = MAX_WIDTH - (MAX_WIDTH % 2);

   // configuration
   logic [12:0] fw_ff, fw_in;
   logic [15:0] fh_ff, fh_in;
   logic        order_ff, order_in;

   // position counters
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [15:0]   in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [15:0]   out_row_ff, out_row_in;

   // window stage and output register
   window_type    win_ff, win_in;
   logic          p1_valid_ff, p1_valid_in;
   pos_flags_type p1_flags_ff, p1_flags_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_data_in;

   logic [XW-1:0] fw_even, w_x;
   logic [WW-1:0] eff_w, col_plus, ocol_plus;
   logic [15:0]   fh_even, eff_h;
   logic          out_free, accept, is_flush, in_frame, ignore, process;
   logic          due_now, last_now;
   pix_type       s, up, lo, up_rd, lo_rd;
   pos_flags_type flags_now;
   rsp_word_type  interp_word;

   // effective frame size
   always_comb begin
      fw_even = XW'({fw_ff[12:1], 1'b0});
      if (fw_even < XW'(2)) begin
         w_x = XW'(2);
      end else if (fw_even > XW'(CAP)) begin
         w_x = XW'(CAP);
      end else begin
         w_x = fw_even;
      end
      eff_w   = w_x[WW-1:0];
      fh_even = {fh_ff[15:1], 1'b0};
      eff_h   = (fh_even < 16'd2) ? 16'd2 : fh_even;
   end

   // handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !p1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_flush       = (req_chan.data.mode == MODE_FLUSH);
   assign in_frame       = in_row_ff < eff_h;
   assign ignore         = is_flush && in_frame;
   assign process        = accept && !ignore;

   // current input word and line store taps
   always_comb begin
      s  = in_frame ? req_chan.data.raw_sample[9:2] : 8'd0;
      up = (in_row_ff >= 16'd2) ? up_rd : 8'd0;
      lo = (in_row_ff >= 16'd1) ? lo_rd : 8'd0;
      due_now  = (in_row_ff >= 16'd2) || ((in_row_ff == 16'd1) && (in_col_ff != '0));
      last_now = {1'b0, in_row_ff} >= ({1'b0, eff_h} + 17'd1);
      col_plus  = {1'b0, in_col_ff} + WW'(1);
      ocol_plus = {1'b0, out_col_ff} + WW'(1);

      flags_now.top  = (out_row_ff == 16'd0);
      flags_now.bot  = (out_row_ff >= (eff_h - 16'd1));
      flags_now.lef  = (out_col_ff == '0);
      flags_now.rig  = ({1'b0, out_col_ff} >= (eff_w - WW'(1)));
      flags_now.oddr = out_row_ff[0];
      flags_now.oddc = out_col_ff[0];
      flags_now.last = last_now;
   end

   // counters and window
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      win_in     = win_ff;
      if (process) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = up;
         win_in[1][2] = lo;
         win_in[2][2] = s;

         if (due_now) begin
            if (ocol_plus >= eff_w) begin
               out_col_in = '0;
               if (out_row_ff != 16'hFFFF) begin
                  out_row_in = out_row_ff + 16'd1;
               end
            end else begin
               out_col_in = ocol_plus[CW-1:0];
            end
         end

         if (last_now) begin
            in_col_in  = '0;
            in_row_in  = 16'd0;
            out_col_in = '0;
            out_row_in = 16'd0;
         end else if (col_plus >= eff_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 16'd1;
         end else begin
            in_col_in = col_plus[CW-1:0];
         end
      end
   end

   // pipeline valids and output register
   always_comb begin
      p1_valid_in  = p1_valid_ff;
      p1_flags_in  = p1_flags_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (p1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = interp_word;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         p1_valid_in = process && due_now;
         p1_flags_in = flags_now;
      end else if (out_free) begin
         p1_valid_in = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      fw_in    = fw_ff;
      fh_in    = fh_ff;
      order_in = order_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fw_in    = csr_wdata[12:0];
            CSR_FRAME_HEIGHT: fh_in    = csr_wdata[15:0];
            CSR_OUTPUT_ORDER: order_in = csr_wdata[0];
            default:          fw_in    = fw_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff        <= FRAME_WIDTH_RESET;
         fh_ff        <= FRAME_HEIGHT_RESET;
         order_ff     <= ORDER_BGR;
         in_col_ff    <= '0;
         in_row_ff    <= 16'd0;
         out_col_ff   <= '0;
         out_row_ff   <= 16'd0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         order_ff     <= order_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      p1_flags_ff <= p1_flags_in;
      rsp_data_ff <= rsp_data_in;
   end

   // line stores: upper holds two rows above the input, lower one row above;
   // read at the next column so data is waiting when the word arrives
   bdm_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_upper_mem (
      .clock   (clock),
      .wr_en   (process),
      .wr_addr (in_col_ff),
      .wr_data (lo),
      .rd_addr (in_col_in),
      .rd_data (up_rd)
   );

   bdm_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_lower_mem (
      .clock   (clock),
      .wr_en   (process),
      .wr_addr (in_col_ff),
      .wr_data (s),
      .rd_addr (in_col_in),
      .rd_data (lo_rd)
   );

   bdm_interp u_interp (
      .win          (win_ff),
      .flags        (p1_flags_ff),
      .output_order (order_ff),
      .word         (interp_word)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // input stalls only when both the window stage and output register are full
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (p1_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("input stalled with room in the pipeline");

   // hold a pending word in the window stage while the output is blocked
   assert property (@(posedge clock) disable iff (reset)
      (p1_valid_ff && !out_free) |=> p1_valid_ff)
      else $error("pending pixel dropped under stall");

   // drop a flush inside the frame without touching the counters
   assert property (@(posedge clock) disable iff (reset)
      (accept && ignore) |=> ($stable(in_col_ff) && $stable(in_row_ff) &&
                              $stable(out_col_ff) && $stable(out_row_ff)))
      else $error("in-frame flush changed position");

   // frame end restarts all positions
   assert property (@(posedge clock) disable iff (reset)
      (process && last_now) |=> ((in_row_ff == 16'd0) && (out_row_ff == 16'd0) &&
                                 (in_col_ff == '0) && (out_col_ff == '0)))
      else $error("counters not cleared at frame end");

endmodule
